[src/fpl_pkg.sv]
// ----------------------------------------------------------------------------
// fpl_pkg
// shared types and codes of the positional fraction list
// ----------------------------------------------------------------------------
`default_nettype none

package fpl_pkg;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_UPDATE = 3'd2;
    localparam logic [2:0] OP_SEARCH = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef enum logic [1:0] {
        CK_HOLD,
        CK_INSERT,
        CK_DELETE,
        CK_UPDATE
    } cell_kind_t;

    typedef struct packed {
        logic signed [31:0] num;
        logic signed [31:0] den;
    } entry_t;

    typedef struct packed {
        cell_kind_t kind;
        logic [5:0] pos;
        entry_t     key;
    } modify_t;

    typedef struct packed {
        logic       search;
        logic [5:0] pos;
        entry_t     key;
    } scan_t;

    typedef struct packed {
        logic   hit;
        entry_t entry;
    } carry_t;

endpackage

`default_nettype wire

[src/positional_fraction_list_core.sv]
// ----------------------------------------------------------------------------
// positional_fraction_list_core
// ordered list of fractions with insert, delete, update, read and search
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid/in_ready carries operation, position, numerator
//   and denominator; output channel out_valid/out_ready carries status,
//   found_index, entries_held, read_numerator and read_denominator
//   every item gives exactly one result item
//   insert, delete, update and rejected items finish in the cycle they are
//   taken: the result is written to the output register at the accepting edge
//   search and read run a match carry down the row of LIST_DEPTH cells, one
//   cell per cycle: the result is taken from cell 0 in S_DONE once the output
//   register is free, so one item per cycle for list edits while the output
//   register is free, and no new item while a lookup is in S_SCAN or S_DONE
//   reset empties the list; entry contents are not cleared
//   a stalled receiver holds the result in the output register; a new item
//   is taken only while that register is free or being emptied
// ----------------------------------------------------------------------------
`default_nettype none

module positional_fraction_list_core
    import fpl_pkg::*;
#(
    parameter int LIST_DEPTH = 32
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire         [2:0]  operation,
    input  wire         [5:0]  position,
    input  wire  signed [31:0] numerator,
    input  wire  signed [31:0] denominator,
    output logic               out_valid,
    input  wire                out_ready,
    output logic        [1:0]  status,
    output logic        [4:0]  found_index,
    output logic        [5:0]  entries_held,
    output logic signed [31:0] read_numerator,
    output logic signed [31:0] read_denominator
);

    localparam int IDX_W = $clog2(LIST_DEPTH);
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [IDX_W-1:0]   wait_reg;
    logic [IDX_W-1:0]   wait_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    scan_t              scan_reg;
    scan_t              scan_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;
    logic [4:0]         found_reg;
    logic [4:0]         found_next;
    logic [5:0]         held_reg;
    logic [5:0]         held_next;
    entry_t             read_reg;
    entry_t             read_next;

    modify_t            modify;
    logic               accept;
    logic               out_free;
    logic               in_range;
    logic               insert_ok;

    entry_t             entries   [LIST_DEPTH];
    carry_t             carries   [LIST_DEPTH];
    logic [IDX_W-1:0]   carry_idx [LIST_DEPTH];

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign in_range  = int'(position) < int'(count_reg);
    assign insert_ok = (int'(count_reg) < LIST_DEPTH) && (int'(position) <= int'(count_reg));

    always_comb
    begin
        state_next       = state_reg;
        wait_next        = wait_reg;
        count_next       = count_reg;
        scan_next        = scan_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        status_next      = status_reg;
        found_next       = found_reg;
        held_next        = held_reg;
        read_next        = read_reg;
        modify.kind      = CK_HOLD;
        modify.pos       = position;
        modify.key.num   = numerator;
        modify.key.den   = denominator;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next    = ST_RANGE;
                    found_next     = '0;
                    read_next      = '0;
                    out_valid_next = 1'b1;
                    scan_next.search  = (operation == OP_SEARCH);
                    scan_next.pos     = position;
                    scan_next.key.num = numerator;
                    scan_next.key.den = denominator;
                    unique case (operation)
                        OP_INSERT:
                        begin
                            if (insert_ok)
                            begin
                                modify.kind = CK_INSERT;
                                count_next  = CNT_W'(count_reg + 1'b1);
                                status_next = ST_DONE;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (in_range)
                            begin
                                modify.kind = CK_DELETE;
                                count_next  = CNT_W'(count_reg - 1'b1);
                                status_next = ST_DONE;
                            end
                        end
                        OP_UPDATE:
                        begin
                            if (in_range)
                            begin
                                modify.kind = CK_UPDATE;
                                status_next = ST_DONE;
                            end
                        end
                        OP_SEARCH:
                        begin
                            out_valid_next = 1'b0;
                            wait_next      = IDX_W'(LIST_DEPTH - 1);
                            state_next     = S_SCAN;
                        end
                        OP_READ:
                        begin
                            if (in_range)
                            begin
                                out_valid_next = 1'b0;
                                wait_next      = IDX_W'(LIST_DEPTH - 1);
                                state_next     = S_SCAN;
                            end
                        end
                        default:
                        begin
                            status_next = ST_RANGE;
                        end
                    endcase
                    held_next = 6'(count_next);
                end
            end
            S_SCAN:
            begin
                if (wait_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    wait_next = wait_reg - 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    held_next      = 6'(count_reg);
                    if (scan_reg.search)
                    begin
                        read_next = '0;
                        if (carries[0].hit)
                        begin
                            status_next = ST_DONE;
                            found_next  = 5'(carry_idx[0]);
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                            found_next  = '0;
                        end
                    end
                    else
                    begin
                        status_next = ST_DONE;
                        found_next  = '0;
                        read_next   = carries[0].entry;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= '0;
            count_reg     <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= '0;
            found_reg     <= '0;
            held_reg      <= '0;
            read_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            wait_reg      <= wait_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            found_reg     <= found_next;
            held_reg      <= held_next;
            read_reg      <= read_next;
        end
    end

    generate
        for (genvar i = 0; i < LIST_DEPTH; i++)
        begin : g_cell
            entry_t           lower;
            entry_t           upper;
            carry_t           c_in;
            logic [IDX_W-1:0] c_idx_in;

            if (i == 0)
            begin : g_first
                assign lower = entries[0];
            end
            else
            begin : g_lower
                assign lower = entries[i-1];
            end

            if (i == LIST_DEPTH - 1)
            begin : g_last
                assign upper    = entries[i];
                assign c_in     = '0;
                assign c_idx_in = '0;
            end
            else
            begin : g_upper
                assign upper    = entries[i+1];
                assign c_in     = carries[i+1];
                assign c_idx_in = carry_idx[i+1];
            end

            fpl_cell #(
                .LIST_DEPTH (LIST_DEPTH),
                .INDEX      (i)
            ) u_cell (
                .clk           (clk),
                .modify        (modify),
                .scan          (scan_reg),
                .count         (count_reg),
                .lower_entry   (lower),
                .upper_entry   (upper),
                .entry         (entries[i]),
                .carry_in      (c_in),
                .carry_idx_in  (c_idx_in),
                .carry_out     (carries[i]),
                .carry_idx_out (carry_idx[i])
            );
        end
    endgenerate

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign found_index      = found_reg;
    assign entries_held     = held_reg;
    assign read_numerator   = read_reg.num;
    assign read_denominator = read_reg.den;

endmodule

`default_nettype wire

[src/fpl_cell.sv]
// ----------------------------------------------------------------------------
// fpl_cell
// one list slot: holds an entry, shifts with its neighbors, forwards a match
// ----------------------------------------------------------------------------
`default_nettype none

module fpl_cell
    import fpl_pkg::*;
#(
    parameter int LIST_DEPTH = 32,
    parameter int INDEX      = 0
) (
    input  wire                                   clk,
    input  modify_t                               modify,
    input  scan_t                                 scan,
    input  wire  [$clog2(LIST_DEPTH+1)-1:0]       count,
    input  entry_t                                lower_entry,
    input  entry_t                                upper_entry,
    output entry_t                                entry,
    input  carry_t                                carry_in,
    input  wire  [$clog2(LIST_DEPTH)-1:0]         carry_idx_in,
    output carry_t                                carry_out,
    output logic [$clog2(LIST_DEPTH)-1:0]         carry_idx_out
);

    localparam int IDX_W = $clog2(LIST_DEPTH);

    entry_t             entry_reg;
    entry_t             entry_next;
    carry_t             carry_reg;
    carry_t             carry_next;
    logic [IDX_W-1:0]   carry_idx_reg;
    logic [IDX_W-1:0]   carry_idx_next;
    logic               match;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (modify.kind)
            CK_HOLD:
            begin
                entry_next = entry_reg;
            end
            CK_INSERT:
            begin
                if (INDEX > int'(modify.pos))
                begin
                    entry_next = lower_entry;
                end
                else if (INDEX == int'(modify.pos))
                begin
                    entry_next = modify.key;
                end
            end
            CK_DELETE:
            begin
                if (INDEX >= int'(modify.pos))
                begin
                    entry_next = upper_entry;
                end
            end
            CK_UPDATE:
            begin
                if (INDEX == int'(modify.pos))
                begin
                    entry_next = modify.key;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_comb
    begin
        if (scan.search)
        begin
            match = (INDEX < int'(count)) && (entry_reg == scan.key);
        end
        else
        begin
            match = (INDEX == int'(scan.pos));
        end
        if (match)
        begin
            carry_next.hit   = 1'b1;
            carry_next.entry = entry_reg;
            carry_idx_next   = IDX_W'(INDEX);
        end
        else
        begin
            carry_next     = carry_in;
            carry_idx_next = carry_idx_in;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg     <= entry_next;
        carry_reg     <= carry_next;
        carry_idx_reg <= carry_idx_next;
    end

    assign entry         = entry_reg;
    assign carry_out     = carry_reg;
    assign carry_idx_out = carry_idx_reg;

endmodule

`default_nettype wire

[dv/positional_fraction_list_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_fraction_list_core_tb
// self-checking bench for the positional fraction list
// a directed opening covers the empty list, edits at both ends and in the
// middle, out of range positions, partial search matches and spare opcodes.
// Random traffic then pushes the list toward full, mixes edits with lookups
// and pushes it back toward empty, under three idling patterns. Every
// accepted request is run through a local model of the list, and each
// result item is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module positional_fraction_list_core_tb;
    import fpl_pkg::*;

    localparam int LIST_DEPTH     = 32;
    localparam int LOOKUP_LATENCY = LIST_DEPTH + 2;
    localparam int CYCLE_LIMIT    = 400000;

    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_MID   = 3'd6;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic        [1:0]  status;
        logic        [4:0]  found;
        logic        [5:0]  held;
        logic signed [31:0] rnum;
        logic signed [31:0] rden;
    } result_t;

    logic               clk;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic        [2:0]  operation   = OP_INSERT;
    logic        [5:0]  position    = '0;
    logic signed [31:0] numerator   = '0;
    logic signed [31:0] denominator = '0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic        [1:0]  status;
    logic        [4:0]  found_index;
    logic        [5:0]  entries_held;
    logic signed [31:0] read_numerator;
    logic signed [31:0] read_denominator;

    // local copy of the list
    entry_t  fraction_list [LIST_DEPTH];
    int      list_count;

    result_t pending_results [$];

    int src_idle_pct;
    int sink_idle_pct;
    int cycle_count;
    int error_count;
    int results_checked;
    int search_hits;
    int full_rejects;
    int requests_by_op [8];

    positional_fraction_list_core #(
        .LIST_DEPTH(LIST_DEPTH)
    ) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .position        (position),
        .numerator       (numerator),
        .denominator     (denominator),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .found_index     (found_index),
        .entries_held    (entries_held),
        .read_numerator  (read_numerator),
        .read_denominator(read_denominator)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= sink_idle_pct);

    // applies one request to the local list and returns its result item
    function automatic result_t list_apply(input logic [2:0] op, input logic [5:0] pos,
                                           input logic signed [31:0] num,
                                           input logic signed [31:0] den);
        result_t r;
        int      i;
        logic    hit;
        r        = '0;
        r.status = ST_RANGE;
        hit      = 1'b0;
        case (op)
            OP_INSERT:
            begin
                if (list_count < LIST_DEPTH && pos <= list_count)
                begin
                    for (i = list_count; i > pos; i--)
                        fraction_list[i] = fraction_list[i - 1];
                    fraction_list[pos].num = num;
                    fraction_list[pos].den = den;
                    list_count++;
                    r.status = ST_DONE;
                end
                else if (list_count == LIST_DEPTH)
                    full_rejects++;
            end
            OP_DELETE:
            begin
                if (pos < list_count)
                begin
                    for (i = pos; i + 1 < list_count; i++)
                        fraction_list[i] = fraction_list[i + 1];
                    list_count--;
                    r.status = ST_DONE;
                end
            end
            OP_UPDATE:
            begin
                if (pos < list_count)
                begin
                    fraction_list[pos].num = num;
                    fraction_list[pos].den = den;
                    r.status = ST_DONE;
                end
            end
            OP_SEARCH:
            begin
                r.status = ST_NOT_FOUND;
                for (i = 0; i < list_count; i++)
                begin
                    if (!hit && fraction_list[i].num == num && fraction_list[i].den == den)
                    begin
                        hit      = 1'b1;
                        r.status = ST_DONE;
                        r.found  = 5'(i);
                    end
                end
                if (hit)
                    search_hits++;
            end
            OP_READ:
            begin
                if (pos < list_count)
                begin
                    r.rnum   = fraction_list[pos].num;
                    r.rden   = fraction_list[pos].den;
                    r.status = ST_DONE;
                end
            end
            default: ;
        endcase
        r.held = 6'(list_count);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result item, expected none, actual status %0d",
                         $time, status);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("found_index", 32'(want.found), 32'(found_index));
                check_field("entries_held", 32'(want.held), 32'(entries_held));
                check_field("read_numerator", want.rnum, read_numerator);
                check_field("read_denominator", want.rden, read_denominator);
                results_checked++;
            end
        end
    end

    task automatic send_request(input logic [2:0] op, input logic [5:0] pos,
                                input logic signed [31:0] num,
                                input logic signed [31:0] den);
        if ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        position    <= pos;
        numerator   <= num;
        denominator <= den;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(list_apply(op, pos, num, den));
        requests_by_op[op]++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return VAL_MIN;
        else if (roll < 20)
            return VAL_MAX;
        else if (roll < 30)
            return -32'sd1;
        else if (roll < 40)
            return 32'sd0;
        else if (roll < 70)
            return 32'($urandom_range(3));
        else
            return 32'($urandom);
    endfunction

    task automatic test_empty_list();
        send_request(OP_READ, 6'd0, 32'sd0, 32'sd0);
        send_request(OP_DELETE, 6'd0, 32'sd0, 32'sd0);
        send_request(OP_UPDATE, 6'd0, 32'sd5, 32'sd7);
        send_request(OP_SEARCH, 6'd0, 32'sd0, 32'sd0);
        send_request(OP_INSERT, 6'd1, 32'sd1, 32'sd2);
    endtask

    task automatic test_edit_and_lookup();
        int i;
        send_request(OP_INSERT, 6'd0, VAL_MIN, VAL_MAX);
        send_request(OP_INSERT, 6'd1, VAL_MAX, VAL_MIN);
        send_request(OP_INSERT, 6'd1, 32'sd0, -32'sd1);
        send_request(OP_INSERT, 6'd3, 32'sd1, 32'sd1);
        send_request(OP_INSERT, 6'd5, 32'sd9, 32'sd9);
        for (i = 0; i < 4; i++)
            send_request(OP_READ, 6'(i), 32'sd0, 32'sd0);
        send_request(OP_SEARCH, 6'd63, VAL_MAX, VAL_MIN);
        // numerator matches but denominator does not
        send_request(OP_SEARCH, 6'd0, VAL_MAX, VAL_MAX);
        send_request(OP_UPDATE, 6'd1, -32'sd1, -32'sd1);
        send_request(OP_SEARCH, 6'd0, -32'sd1, -32'sd1);
        send_request(OP_DELETE, 6'd0, 32'sd0, 32'sd0);
        send_request(OP_DELETE, 6'd2, 32'sd0, 32'sd0);
        send_request(OP_READ, 6'd63, 32'sd0, 32'sd0);
        send_request(OP_DELETE, 6'(list_count), 32'sd0, 32'sd0);
    endtask

    task automatic test_spare_opcodes();
        send_request(OP_SPARE_FIRST, 6'd0, 32'sd1, 32'sd1);
        send_request(OP_SPARE_MID, 6'd0, 32'sd1, 32'sd1);
        send_request(OP_SPARE_LAST, 6'd0, 32'sd1, 32'sd1);
    endtask

    // insert_weight steers the list toward full or toward empty
    task automatic random_segment(input int items, input int insert_weight);
        logic        [2:0]  op;
        logic        [5:0]  pos;
        logic signed [31:0] num;
        logic signed [31:0] den;
        int                 roll;
        int                 rest;
        int                 n;
        int                 idx;
        for (n = 0; n < items; n++)
        begin
            roll = $urandom_range(99);
            rest = 97 - insert_weight;
            if (roll < 3)
                op = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
            else if (roll < 3 + insert_weight)
                op = OP_INSERT;
            else if (roll < 3 + insert_weight + rest * 30 / 100)
                op = OP_DELETE;
            else if (roll < 3 + insert_weight + rest * 50 / 100)
                op = OP_UPDATE;
            else if (roll < 3 + insert_weight + rest * 75 / 100)
                op = OP_SEARCH;
            else
                op = OP_READ;

            roll = $urandom_range(99);
            if (roll < 12)
                pos = 6'($urandom_range(63));
            else if (roll < 18)
                pos = 6'(list_count);
            else if (op == OP_INSERT)
                pos = 6'($urandom_range(list_count));
            else if (list_count > 0)
                pos = 6'($urandom_range(list_count - 1));
            else
                pos = 6'($urandom_range(63));

            num = pick_value();
            den = pick_value();
            if (op == OP_SEARCH && list_count > 0)
            begin
                idx  = $urandom_range(list_count - 1);
                roll = $urandom_range(99);
                if (roll < 50)
                begin
                    num = fraction_list[idx].num;
                    den = fraction_list[idx].den;
                end
                else if (roll < 70)
                    num = fraction_list[idx].num;
            end
            send_request(op, pos, num, den);
        end
    endtask

    task automatic test_random_traffic();
        random_segment(40, 80);
        random_segment(50, 35);
        random_segment(80, 15);
    endtask

    initial
    begin
        list_count      = 0;
        search_hits     = 0;
        full_rejects    = 0;
        foreach (requests_by_op[i])
            requests_by_op[i] = 0;
        foreach (fraction_list[i])
            fraction_list[i] = '0;
        src_idle_pct  = 11;
        sink_idle_pct = 69;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_edit_and_lookup();
        test_spare_opcodes();
        test_random_traffic();
        // hold the sender off until every result is back
        drain_results();

        src_idle_pct  = 69;
        sink_idle_pct = 11;
        test_random_traffic();
        drain_results();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_traffic();
        drain_results();

        repeat (2 * LOOKUP_LATENCY) @(posedge clk);

        $display("covered %0d inserts, %0d deletes, %0d updates, %0d searches, %0d reads",
                 requests_by_op[OP_INSERT], requests_by_op[OP_DELETE],
                 requests_by_op[OP_UPDATE], requests_by_op[OP_SEARCH], requests_by_op[OP_READ]);
        $display("%0d results checked, %0d search hits, %0d inserts refused on a full list",
                 results_checked, search_hits, full_rejects);
        if (error_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[positional_fraction_list_core.f]
src/fpl_pkg.sv
src/fpl_cell.sv
src/positional_fraction_list_core.sv
dv/positional_fraction_list_core_tb.sv
